/* src/blws_pkg.sv */
// ----------------------------------------------------------------------------
// blws_pkg
// Shared types and codes for the bounded list with search.
// ----------------------------------------------------------------------------
package blws_pkg;

  // Width of one stored value.
  localparam int VALUE_W = 32;

  // Width of the action selector and of the status code.
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;

  // Action carried with each request.
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT   = 2'd0,
    ACT_APPEND_BACK  = 2'd1,
    ACT_REMOVE_FRONT = 2'd2,
    ACT_SEARCH       = 2'd3
  } action_t;

  // Status reported with each result.
  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Result flags handed from the sequencer to the output stage.
  typedef struct packed {
    logic    found;
    status_t status;
  } result_t;

endpackage

/* src/blws_mem.sv */
// ----------------------------------------------------------------------------
// blws_mem
// Entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module blws_mem #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [$clog2(DEPTH)-1:0]            waddr,
  input  logic [blws_pkg::VALUE_W-1:0]        wdata,
  input  logic                                re,
  input  logic [$clog2(DEPTH)-1:0]            raddr,
  output logic [blws_pkg::VALUE_W-1:0]        rdata
);

  logic [blws_pkg::VALUE_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; read data is registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/blws_seq.sv */
// ----------------------------------------------------------------------------
// blws_seq
// Sequencer: keeps the front position and count, writes inserted values and
// walks the stored entries through the memory read port during a search.
// ----------------------------------------------------------------------------
module blws_seq #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // Request side.
  output logic                                idle,
  input  logic                                req_valid,
  input  blws_pkg::action_t                   req_action,
  input  logic [blws_pkg::VALUE_W-1:0]        req_value,
  // Result side.
  input  logic                                out_free,
  output logic                                res_valid,
  output blws_pkg::result_t                   res,
  output logic [$clog2(DEPTH+1)-1:0]          res_count,
  // Memory port.
  output logic                                mem_we,
  output logic [$clog2(DEPTH)-1:0]            mem_waddr,
  output logic [blws_pkg::VALUE_W-1:0]        mem_wdata,
  output logic                                mem_re,
  output logic [$clog2(DEPTH)-1:0]            mem_raddr,
  input  logic [blws_pkg::VALUE_W-1:0]        mem_rdata
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_RESP   = 3'b100
  } state_t;

  state_t                         state, state_next;
  logic [IW-1:0]                  front, front_next;
  logic [CW-1:0]                  count, count_next;
  logic [CW-1:0]                  ptr, ptr_next;
  logic [IW-1:0]                  walk, walk_next;
  logic [blws_pkg::VALUE_W-1:0]   key, key_next;
  blws_pkg::result_t              pend, pend_next;

  logic [IW-1:0]                  front_inc, front_dec, walk_inc, back_slot;
  logic [IW:0]                    back_sum;
  logic                           full, empty, match;
  blws_pkg::result_t              res_now;

  // Circular position arithmetic; every step stays below twice the depth.
  always_comb begin
    front_inc = (front == IW'(DEPTH - 1)) ? '0 : front + 1'b1;
    front_dec = (front == '0) ? IW'(DEPTH - 1) : front - 1'b1;
    walk_inc  = (walk == IW'(DEPTH - 1)) ? '0 : walk + 1'b1;
    back_sum  = (IW + 1)'(front) + (IW + 1)'(count);
    if (back_sum >= (IW + 1)'(DEPTH)) begin
      back_slot = IW'(back_sum - (IW + 1)'(DEPTH));
    end else begin
      back_slot = IW'(back_sum);
    end
  end

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign match = (mem_rdata == key);

  // Next-state logic for the sequencer.
  always_comb begin
    state_next = state;
    front_next = front;
    count_next = count;
    ptr_next   = ptr;
    walk_next  = walk;
    key_next   = key;
    pend_next  = pend;
    res_now    = '{found: 1'b0, status: blws_pkg::STAT_DONE};
    res_valid  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = front_dec;
    mem_wdata  = req_value;
    mem_re     = 1'b0;
    mem_raddr  = walk;
    idle       = (state == S_IDLE);

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (req_action)
            blws_pkg::ACT_PUSH_FRONT: begin
              if (full) begin
                res_now.status = blws_pkg::STAT_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = front_dec;
                front_next = front_dec;
                count_next = count + 1'b1;
              end
            end
            blws_pkg::ACT_APPEND_BACK: begin
              if (full) begin
                res_now.status = blws_pkg::STAT_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = back_slot;
                count_next = count + 1'b1;
              end
            end
            blws_pkg::ACT_REMOVE_FRONT: begin
              if (empty) begin
                res_now.status = blws_pkg::STAT_EMPTY;
              end else begin
                front_next = front_inc;
                count_next = count - 1'b1;
              end
            end
            blws_pkg::ACT_SEARCH: begin
              // Start the walk at the front unless there is nothing to read.
              if (!empty) begin
                mem_re     = 1'b1;
                mem_raddr  = front;
                walk_next  = front_inc;
                ptr_next   = CW'(1);
                key_next   = req_value;
                state_next = S_SEARCH;
              end
            end
            default: ;
          endcase

          // Answer right away unless a search walk has started.
          if (!(req_action == blws_pkg::ACT_SEARCH && !empty)) begin
            if (out_free) begin
              res_valid = 1'b1;
            end else begin
              pend_next  = res_now;
              state_next = S_RESP;
            end
          end
        end
      end

      S_SEARCH: begin
        // Read data belongs to the entry at offset ptr - 1.
        if (match || ptr == count) begin
          res_now.found = match;
          if (out_free) begin
            res_valid  = 1'b1;
            state_next = S_IDLE;
          end else begin
            pend_next  = res_now;
            state_next = S_RESP;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = walk;
          walk_next = walk_inc;
          ptr_next  = ptr + 1'b1;
        end
      end

      S_RESP: begin
        res_now = pend;
        if (out_free) begin
          res_valid  = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    res       = res_now;
    res_count = count_next;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
    end
  end

  // Search bookkeeping and the held result.
  always_ff @(posedge clk) begin
    ptr  <= ptr_next;
    walk <= walk_next;
    key  <= key_next;
    pend <= pend_next;
  end

endmodule

/* src/bounded_list_with_search_top.sv */
// ----------------------------------------------------------------------------
// bounded_list_with_search_top
// Bounded circular list of signed 32-bit values with insert, append, remove
// and search, one result per request.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. Insert, append and remove are answered
// from the idle state without a walk; a search reads one stored entry per
// cycle through the single read port of the entry memory until it stops at
// the first hit, or after the last stored entry on a miss. A search on an
// empty list answers without reading the memory. Results sit in an output
// register, so a new request is taken while the previous result waits; a
// stalled output holds the sequencer in a one-entry result buffer.
module bounded_list_with_search_top #(
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  // Request stream.
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  // tdata: value[31:0]
  input  logic [blws_pkg::VALUE_W-1:0]                 s_axis_tdata,
  // tuser: action[1:0]
  input  logic [blws_pkg::ACTION_W-1:0]                s_axis_tuser,
  // Result stream.
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  // tdata: status[1:0], found[2], count[3 +: $clog2(DEPTH+1)], zero fill
  output logic [((3 + $clog2(DEPTH + 1) + 7) / 8) * 8-1:0] m_axis_tdata
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IW    = $clog2(DEPTH);
  localparam int OUT_W = ((3 + CW + 7) / 8) * 8;

  logic                          seq_idle;
  logic                          out_free;
  logic                          res_valid;
  blws_pkg::result_t             res;
  logic [CW-1:0]                 res_count;
  logic                          mem_we, mem_re;
  logic [IW-1:0]                 mem_waddr, mem_raddr;
  logic [blws_pkg::VALUE_W-1:0]  mem_wdata, mem_rdata;

  assign s_axis_tready = seq_idle;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  blws_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .idle       (seq_idle),
    .req_valid  (s_axis_tvalid),
    .req_action (blws_pkg::action_t'(s_axis_tuser)),
    .req_value  (s_axis_tdata),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res),
    .res_count  (res_count),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  blws_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register for the result stream.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_axis_tdata <= OUT_W'({res_count, res.found, res.status});
    end
  end

  // A full report always comes with a list that holds DEPTH entries.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == blws_pkg::STAT_FULL |-> res_count == CW'(DEPTH))
    else $error("full status with count below depth");

  // An empty report always comes with a count of zero.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == blws_pkg::STAT_EMPTY |-> res_count == '0)
    else $error("empty status with nonzero count");

  // A hit is only ever reported with a done status.
  a_found_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.found |-> res.status == blws_pkg::STAT_DONE)
    else $error("found flag with error status");

  // A new result is never produced while the output register is stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !res_valid)
    else $error("result written over a stalled output");

endmodule
